// File: src/vertex_normal_accumulator_unit_macros.svh
// ----------------------------------------------------------------------------
// Vertex normal accumulator assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef VERTEX_NORMAL_ACCUMULATOR_UNIT_MACROS_SVH
`define VERTEX_NORMAL_ACCUMULATOR_UNIT_MACROS_SVH

// same-cycle implication
`define VNA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define VNA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/vna_pkg.sv
// ----------------------------------------------------------------------------
// vna_pkg
// Types, widths and helpers shared by the vertex normal accumulator.
// ----------------------------------------------------------------------------
package vna_pkg;

  localparam int VERTEX_COUNT = 1024;
  localparam int VTX_AW       = $clog2(VERTEX_COUNT);
  localparam int IDX_W        = 10;
  localparam int POS_W        = 20;
  localparam int EDGE_W       = 21;
  localparam int PROD_W       = 42;
  localparam int CROSS_W      = 43;
  localparam int SUM_W        = 48;
  localparam int NRM_W        = 16;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_FACE  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } vtx_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] x;
    logic signed [SUM_W-1:0] y;
    logic signed [SUM_W-1:0] z;
  } sum_t;

  typedef struct packed {
    logic signed [NRM_W-1:0] x;
    logic signed [NRM_W-1:0] y;
    logic signed [NRM_W-1:0] z;
    logic                    zero;
  } norm_res_t;

  function automatic logic in_range(input logic [IDX_W-1:0] i);
    return 32'(i) < 32'(VERTEX_COUNT);
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0]   s,
    input logic signed [CROSS_W-1:0] d
  );
    logic signed [SUM_W:0] r;
    r = (SUM_W+1)'(s) + (SUM_W+1)'(d);
    if (r[SUM_W] != r[SUM_W-1]) begin
      return r[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    return r[SUM_W-1:0];
  endfunction

endpackage

// File: src/vna_ram.sv
// ----------------------------------------------------------------------------
// vna_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module vna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/vna_norm.sv
// ----------------------------------------------------------------------------
// vna_norm
// Iterative normalizer: scale, sum of squares, bit-serial square root and
// three 16-step divisions sharing one divider.
// ----------------------------------------------------------------------------
module vna_norm import vna_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  sum_t      sum,
  output norm_res_t res,
  output logic      done
);

  typedef enum logic [7:0] {
    N_IDLE  = 8'b0000_0001,
    N_MAG   = 8'b0000_0010,
    N_SHIFT = 8'b0000_0100,
    N_SQ    = 8'b0000_1000,
    N_SQRT  = 8'b0001_0000,
    N_DINIT = 8'b0010_0000,
    N_DIV   = 8'b0100_0000,
    N_DONE  = 8'b1000_0000
  } nst_t;

  nst_t              st;
  logic [SUM_W-1:0]  mag [3];
  logic [2:0]        neg;
  logic [SUM_W-1:0]  m;
  logic [1:0]        step;
  logic [61:0]       acc;
  logic [61:0]       root;
  logic [60:0]       sbit;
  logic [31:0]       rem;
  logic [15:0]       nlo;
  logic [15:0]       q;
  logic [3:0]        cnt;

  logic [SUM_W-1:0]  mmax;
  logic [29:0]       msel;
  logic [59:0]       sq;
  logic [61:0]       trial;
  logic [31:0]       len;
  logic [46:0]       num;
  logic [32:0]       r2;
  logic [15:0]       q_next;
  logic [NRM_W-1:0]  cres;

  always_comb begin
    mmax = mag[0];
    if (mag[1] > mmax) mmax = mag[1];
    if (mag[2] > mmax) mmax = mag[2];
    case (step)
      2'd0:    msel = mag[0][29:0];
      2'd1:    msel = mag[1][29:0];
      default: msel = mag[2][29:0];
    endcase
    sq     = 60'(msel) * 60'(msel);
    trial  = root + 62'(sbit);
    len    = root[31:0];
    num    = (47'(msel) << 15) + 47'(len >> 1);
    r2     = {rem, nlo[15]};
    q_next = {q[14:0], r2 >= {1'b0, len}};
    cres   = q_next[15] ? NRM_W'(16'h7fff) : q_next;
    if (neg[step]) cres = -cres;
  end

  assign done = (st == N_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= N_IDLE;
    end else begin
      case (st)
        N_IDLE, N_DONE: begin
          if (start) begin
            mag[0] <= sum.x[SUM_W-1] ? -sum.x : sum.x;
            mag[1] <= sum.y[SUM_W-1] ? -sum.y : sum.y;
            mag[2] <= sum.z[SUM_W-1] ? -sum.z : sum.z;
            neg    <= {sum.z[SUM_W-1], sum.y[SUM_W-1], sum.x[SUM_W-1]};
            st     <= N_MAG;
          end
        end
        N_MAG: begin
          m <= mmax;
          if (mmax == '0) begin
            res <= '{x: '0, y: '0, z: '0, zero: 1'b1};
            st  <= N_DONE;
          end else begin
            st <= N_SHIFT;
          end
        end
        N_SHIFT: begin
          if (m[SUM_W-1:30] != '0) begin
            m <= m >> 1;
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
          end else if (!m[29]) begin
            m <= m << 1;
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
          end else begin
            step <= 2'd0;
            acc  <= '0;
            st   <= N_SQ;
          end
        end
        N_SQ: begin
          acc <= acc + 62'(sq);
          if (step == 2'd2) begin
            root <= '0;
            sbit <= 61'(1) << 60;
            st   <= N_SQRT;
          end else begin
            step <= step + 2'd1;
          end
        end
        N_SQRT: begin
          if (acc >= trial) begin
            acc  <= acc - trial;
            root <= (root >> 1) + 62'(sbit);
          end else begin
            root <= root >> 1;
          end
          sbit <= sbit >> 2;
          if (sbit[0]) begin
            step <= 2'd0;
            st   <= N_DINIT;
          end
        end
        N_DINIT: begin
          rem <= 32'(num[46:16]);
          nlo <= num[15:0];
          q   <= '0;
          cnt <= '0;
          st  <= N_DIV;
        end
        N_DIV: begin
          rem <= (r2 >= {1'b0, len}) ? 32'(r2 - {1'b0, len}) : r2[31:0];
          nlo <= nlo << 1;
          q   <= q_next;
          cnt <= cnt + 4'd1;
          if (cnt == 4'd15) begin
            case (step)
              2'd0:    res.x <= cres;
              2'd1:    res.y <= cres;
              default: res.z <= cres;
            endcase
            res.zero <= 1'b0;
            if (step == 2'd2) begin
              st <= N_DONE;
            end else begin
              step <= step + 2'd1;
              st   <= N_DINIT;
            end
          end
        end
        default: st <= N_IDLE;
      endcase
    end
  end

endmodule

// File: src/vertex_normal_accumulator_unit.sv
// ----------------------------------------------------------------------------
// vertex_normal_accumulator_unit
// Area-weighted vertex normals: vertex RAM, normal-sum RAM with
// read-modify-write, and an iterative normalizer.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | command, vertex_index, pos_*, corner_*
//   out     | output    | out_valid / out_ready| normal_x/y/z, zero_length
//
// Write vertex: stored as it is accepted. Face: 3 vertex reads, edges, products,
// cross, then read and write back each corner sum in turn through one port each.
// Read: scale loop, 31-step square root and three 16-step divisions in the
// normalizer, all skipped for a zero sum. After reset a sweep zeroes all 1024
// sum RAM entries; in_ready stays low. A result waits in the output register;
// a read stalls only its last step.
// ----------------------------------------------------------------------------
`include "vertex_normal_accumulator_unit_macros.svh"

module vertex_normal_accumulator_unit import vna_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              command,
  input  logic [IDX_W-1:0]        vertex_index,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [POS_W-1:0] pos_z,
  input  logic [IDX_W-1:0]        corner_a,
  input  logic [IDX_W-1:0]        corner_b,
  input  logic [IDX_W-1:0]        corner_c,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [NRM_W-1:0] normal_x,
  output logic signed [NRM_W-1:0] normal_y,
  output logic signed [NRM_W-1:0] normal_z,
  output logic                    zero_length
);

  typedef enum logic [10:0] {
    ST_CLEAR  = 11'b000_0000_0001,
    ST_IDLE   = 11'b000_0000_0010,
    ST_VRD    = 11'b000_0000_0100,
    ST_EDGE   = 11'b000_0000_1000,
    ST_MUL    = 11'b000_0001_0000,
    ST_CSUB   = 11'b000_0010_0000,
    ST_SRD    = 11'b000_0100_0000,
    ST_SWR    = 11'b000_1000_0000,
    ST_NRD    = 11'b001_0000_0000,
    ST_NSTART = 11'b010_0000_0000,
    ST_NWAIT  = 11'b100_0000_0000
  } st_t;

  st_t                      st;
  logic [VTX_AW-1:0]        clr_cnt;
  logic [VTX_AW-1:0]        idx;
  logic                     idx_ok;
  logic [VTX_AW-1:0]        crn [3];
  logic [1:0]               step;
  vtx_t                     p [3];
  logic signed [EDGE_W-1:0] e1x, e1y, e1z, e2x, e2y, e2z;
  logic signed [PROD_W-1:0] pyz, pzy, pzx, pxz, pxy, pyx;
  logic signed [CROSS_W-1:0] cx, cy, cz;

  logic                     vram_we, vram_re, sram_we, sram_re;
  logic [VTX_AW-1:0]        vram_waddr, vram_raddr, sram_waddr, sram_raddr;
  logic [3*POS_W-1:0]       vram_rdata;
  logic [3*SUM_W-1:0]       sram_wdata, sram_rdata;
  logic [VTX_AW-1:0]        crn_sel;
  sum_t                     sum_rd, sum_wr;
  logic                     in_fire, out_load, norm_start, norm_done;
  norm_res_t                norm_res;

  assign in_ready = (st == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_load = (st == ST_NWAIT) && norm_done && (!out_valid || out_ready);
  assign norm_start = (st == ST_NSTART);
  assign sum_rd   = sum_t'(sram_rdata);

  always_comb begin
    case (step)
      2'd0:    crn_sel = crn[0];
      2'd1:    crn_sel = crn[1];
      default: crn_sel = crn[2];
    endcase
    sum_wr.x = sat_add(sum_rd.x, cx);
    sum_wr.y = sat_add(sum_rd.y, cy);
    sum_wr.z = sat_add(sum_rd.z, cz);

    vram_we    = in_fire && (cmd_t'(command) == CMD_WRITE) && in_range(vertex_index);
    vram_waddr = VTX_AW'(vertex_index);
    vram_re    = (st == ST_VRD);
    vram_raddr = crn_sel;

    sram_we    = vram_we;
    sram_waddr = VTX_AW'(vertex_index);
    sram_wdata = '0;
    if (st == ST_CLEAR) begin
      sram_we    = 1'b1;
      sram_waddr = clr_cnt;
    end else if (st == ST_SWR) begin
      sram_we    = 1'b1;
      sram_waddr = crn_sel;
      sram_wdata = sum_wr;
    end
    sram_re    = (st == ST_SRD) || (st == ST_NRD);
    sram_raddr = (st == ST_NRD) ? idx : crn_sel;
  end

  vna_ram #(.WIDTH(3*POS_W), .DEPTH(VERTEX_COUNT)) u_vtx_ram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (vram_waddr),
    .wdata ({pos_x, pos_y, pos_z}),
    .re    (vram_re),
    .raddr (vram_raddr),
    .rdata (vram_rdata)
  );

  vna_ram #(.WIDTH(3*SUM_W), .DEPTH(VERTEX_COUNT)) u_sum_ram (
    .clk   (clk),
    .we    (sram_we),
    .waddr (sram_waddr),
    .wdata (sram_wdata),
    .re    (sram_re),
    .raddr (sram_raddr),
    .rdata (sram_rdata)
  );

  vna_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (norm_start),
    .sum   (idx_ok ? sum_rd : sum_t'('0)),
    .res   (norm_res),
    .done  (norm_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (st)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == VTX_AW'(VERTEX_COUNT-1)) st <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_fire) begin
            idx    <= VTX_AW'(vertex_index);
            idx_ok <= in_range(vertex_index);
            crn[0] <= VTX_AW'(corner_a);
            crn[1] <= VTX_AW'(corner_b);
            crn[2] <= VTX_AW'(corner_c);
            step   <= 2'd0;
            case (cmd_t'(command))
              CMD_FACE: begin
                if (in_range(corner_a) && in_range(corner_b) && in_range(corner_c)) begin
                  st <= ST_VRD;
                end
              end
              CMD_READ: st <= ST_NRD;
              default:  st <= ST_IDLE;
            endcase
          end
        end
        ST_VRD: begin
          case (step)
            2'd1:    p[0] <= vtx_t'(vram_rdata);
            2'd2:    p[1] <= vtx_t'(vram_rdata);
            2'd3:    p[2] <= vtx_t'(vram_rdata);
            default: ;
          endcase
          step <= step + 2'd1;
          if (step == 2'd3) st <= ST_EDGE;
        end
        ST_EDGE: begin
          e1x <= EDGE_W'(p[1].x) - EDGE_W'(p[0].x);
          e1y <= EDGE_W'(p[1].y) - EDGE_W'(p[0].y);
          e1z <= EDGE_W'(p[1].z) - EDGE_W'(p[0].z);
          e2x <= EDGE_W'(p[2].x) - EDGE_W'(p[0].x);
          e2y <= EDGE_W'(p[2].y) - EDGE_W'(p[0].y);
          e2z <= EDGE_W'(p[2].z) - EDGE_W'(p[0].z);
          st  <= ST_MUL;
        end
        ST_MUL: begin
          pyz <= e1y * e2z;
          pzy <= e1z * e2y;
          pzx <= e1z * e2x;
          pxz <= e1x * e2z;
          pxy <= e1x * e2y;
          pyx <= e1y * e2x;
          st  <= ST_CSUB;
        end
        ST_CSUB: begin
          cx   <= CROSS_W'(pyz) - CROSS_W'(pzy);
          cy   <= CROSS_W'(pzx) - CROSS_W'(pxz);
          cz   <= CROSS_W'(pxy) - CROSS_W'(pyx);
          step <= 2'd0;
          st   <= ST_SRD;
        end
        ST_SRD: st <= ST_SWR;
        ST_SWR: begin
          if (step == 2'd2) begin
            st <= ST_IDLE;
          end else begin
            step <= step + 2'd1;
            st   <= ST_SRD;
          end
        end
        ST_NRD:    st <= ST_NSTART;
        ST_NSTART: st <= ST_NWAIT;
        ST_NWAIT: begin
          if (out_load) st <= ST_IDLE;
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      normal_x    <= norm_res.x;
      normal_y    <= norm_res.y;
      normal_z    <= norm_res.z;
      zero_length <= norm_res.zero;
    end
  end

  `VNA_ASSERT_IMP(a_out_from_norm, $rose(out_valid), $past(st == ST_NWAIT) && $past(norm_done), "result loaded outside normalize completion")
  `VNA_ASSERT_IMP(a_no_sum_clash, sram_we && sram_re, sram_waddr != sram_raddr, "sum RAM read and write hit the same entry")
  `VNA_ASSERT_NXT(a_clear_ends, st == ST_CLEAR && clr_cnt == VTX_AW'(VERTEX_COUNT-1), st == ST_IDLE, "clear sweep did not end")

endmodule
